FILE: design/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types and constants for the latency statistics monitor.
// ----------------------------------------------------------------------------
package lsm_pkg;

  localparam int unsigned TS_W    = 62;  // timestamp in ns
  localparam int unsigned LAT_W   = 48;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned IMG_W   = 27;
  localparam int unsigned BW_W    = 48;
  localparam int unsigned PROD_W  = 59;  // count * image bytes
  localparam int unsigned NUM_W   = 89;  // product * 1e9

  localparam int unsigned AVG_STEPS = 64;
  localparam int unsigned BW_STEPS  = 48;

  localparam logic [29:0]        NS_PER_SEC    = 30'd1000000000;
  localparam logic [IMG_W-1:0]   IMG_RESET     = 27'd1048576;
  localparam logic [LAT_W-1:0]   LAT_MIN_RESET = 48'd1000000000000;
  localparam logic [LAT_W-1:0]   LAT_HI        = {1'b0, {(LAT_W-1){1'b1}}};
  localparam logic [LAT_W-1:0]   LAT_LO        = {1'b1, {(LAT_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]   SUM_HI        = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]   SUM_LO        = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]   CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [BW_W-1:0]    BW_MAX        = {BW_W{1'b1}};

  typedef struct packed {
    logic [30:0] send_sec;
    logic [29:0] send_nanosec;
    logic [30:0] recv_sec;
    logic [29:0] recv_nanosec;
  } in_item_t;

  typedef struct packed {
    logic signed [LAT_W-1:0] latency_ns;
    logic signed [LAT_W-1:0] min_latency_ns;
    logic signed [LAT_W-1:0] max_latency_ns;
    logic signed [LAT_W-1:0] avg_latency_ns;
    logic [CNT_W-1:0]        seen_count;
    logic [BW_W-1:0]         bandwidth_bps;
  } out_item_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic signed [LAT_W-1:0] latency;
    logic [TS_W-1:0]         recv_ns;
  } lsm_item_t;

endpackage

FILE: design/lsm_front.sv
// ----------------------------------------------------------------------------
// lsm_front
// Accepts timestamp pairs, converts them to ns and forms the clamped latency.
// ----------------------------------------------------------------------------
module lsm_front import lsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      push,
  output lsm_item_t push_data,
  input  logic      q_full
);

  logic            s1_v_r;
  logic [TS_W-1:0] send_ns_r, recv_ns_r;
  logic [60:0]     send_mul, recv_mul;
  logic [62:0]     diff;
  logic            hi_ovf, lo_ovf;

  assign in_stall = s1_v_r && q_full;
  assign push     = s1_v_r && !q_full;

  assign send_mul = 61'(in_data.send_sec) * 61'(NS_PER_SEC);
  assign recv_mul = 61'(in_data.recv_sec) * 61'(NS_PER_SEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      send_ns_r <= TS_W'(send_mul) + TS_W'(in_data.send_nanosec);
      recv_ns_r <= TS_W'(recv_mul) + TS_W'(in_data.recv_nanosec);
    end
  end

  assign diff   = {1'b0, recv_ns_r} - {1'b0, send_ns_r};
  assign hi_ovf = !diff[62] && (diff[62:LAT_W-1] != '0);
  assign lo_ovf = diff[62] && (diff[62:LAT_W-1] != '1);

  always_comb begin
    push_data.recv_ns = recv_ns_r;
    priority if (hi_ovf) begin
      push_data.latency = LAT_HI;
    end else if (lo_ovf) begin
      push_data.latency = LAT_LO;
    end else begin
      push_data.latency = diff[LAT_W-1:0];
    end
  end

endmodule

FILE: design/lsm_fifo.sv
// ----------------------------------------------------------------------------
// lsm_fifo
// Short queue between the front and the back of the monitor.
// ----------------------------------------------------------------------------
module lsm_fifo import lsm_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lsm_item_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output lsm_item_t pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lsm_item_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/lsm_back.sv
// ----------------------------------------------------------------------------
// lsm_back
// Updates the running statistics and runs the average and bandwidth dividers.
// ----------------------------------------------------------------------------
module lsm_back import lsm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IMG_W-1:0] image_bytes,
  input  logic             q_not_empty,
  input  lsm_item_t        q_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_UPD, ST_MUL0, ST_MUL1, ST_MUL2, ST_ADD, ST_CHK, ST_DIV, ST_FIN
  } state_t;

  localparam int unsigned SW = $clog2(AVG_STEPS);
  localparam logic [SW-1:0] AVG_LAST = SW'(AVG_STEPS - 1);
  localparam logic [SW-1:0] BW_END   = SW'(BW_STEPS);

  state_t state_r;

  // running statistics
  logic signed [LAT_W-1:0] min_r, max_r;
  logic [SUM_W-1:0]        sum_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [TS_W-1:0]         first_r;
  logic                    started_r;

  // per-item working registers
  logic signed [LAT_W-1:0] lat_r;
  logic [TS_W-1:0]         recv_r;
  logic [TS_W-1:0]         elap_r;
  logic                    bw_en_r, bw_sat_r;
  logic [PROD_W-1:0]       prod_r;
  logic [56:0]             pa_r;
  logic [61:0]             pb_r;
  logic [NUM_W-1:0]        num_r;
  logic [SUM_W-1:0]        aq_r;
  logic [CNT_W-1:0]        ar_r;
  logic [BW_W-1:0]         bq_r;
  logic [TS_W-1:0]         br_r;
  logic [SW-1:0]           step_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  // combinational helpers
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_nxt;
  logic [TS_W-1:0]  first_nxt;
  logic [SUM_W-1:0] sum_mag;
  logic [CNT_W:0]   a_trial;
  logic             a_ge;
  logic [TS_W:0]    b_trial;
  logic             b_ge;
  logic             out_free;
  logic [LAT_W-1:0] avg_val;
  logic [BW_W-1:0]  bw_val;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (state_r == ST_IDLE) && q_not_empty;

  assign sum_ext = {sum_r[SUM_W-1], sum_r} + (SUM_W+1)'(signed'(lat_r));
  always_comb begin
    unique case (sum_ext[SUM_W:SUM_W-1])
      2'b01:   sum_nxt = SUM_HI;
      2'b10:   sum_nxt = SUM_LO;
      default: sum_nxt = sum_ext[SUM_W-1:0];
    endcase
  end

  assign first_nxt = started_r ? first_r : recv_r;
  assign sum_mag   = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  assign a_trial = {ar_r, aq_r[SUM_W-1]};
  assign a_ge    = (a_trial >= {1'b0, cnt_r});
  assign b_trial = {br_r, bq_r[BW_W-1]};
  assign b_ge    = (b_trial >= {1'b0, elap_r});

  // average (truncated, sign restored, clamped to 48 bits) and bandwidth select
  always_comb begin
    if (sum_r[SUM_W-1]) begin
      if (aq_r > SUM_W'(LAT_LO)) begin
        avg_val = LAT_LO;
      end else begin
        avg_val = LAT_W'(~aq_r + 1'b1);
      end
    end else begin
      if (aq_r > SUM_W'(LAT_HI)) begin
        avg_val = LAT_HI;
      end else begin
        avg_val = aq_r[LAT_W-1:0];
      end
    end
    priority if (!bw_en_r) begin
      bw_val = '0;
    end else if (bw_sat_r) begin
      bw_val = BW_MAX;
    end else begin
      bw_val = bq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= LAT_MIN_RESET;
      max_r       <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      first_r     <= '0;
      started_r   <= 1'b0;
      step_r      <= '0;
    end else begin
      // in ST_FIN the valid bit is handled by the result load below
      if (out_valid_r && !out_stall && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            lat_r   <= q_data.latency;
            recv_r  <= q_data.recv_ns;
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          started_r <= 1'b1;
          first_r   <= first_nxt;
          if (lat_r < min_r) begin
            min_r <= lat_r;
          end
          if (lat_r > max_r) begin
            max_r <= lat_r;
          end
          sum_r <= sum_nxt;
          if (cnt_r != CNT_MAX) begin
            cnt_r <= cnt_r + 1'b1;
          end
          elap_r  <= recv_r - first_nxt;
          bw_en_r <= (recv_r > first_nxt) && (image_bytes != '0);
          state_r <= ST_MUL0;
        end
        ST_MUL0: begin
          prod_r  <= PROD_W'(cnt_r) * PROD_W'(image_bytes);
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          pa_r    <= 57'(prod_r[PROD_W-1:32]) * 57'(NS_PER_SEC);
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          pb_r    <= 62'(prod_r[31:0]) * 62'(NS_PER_SEC);
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          num_r   <= {pa_r, 32'b0} + NUM_W'(pb_r);
          aq_r    <= sum_mag;
          ar_r    <= '0;
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          // quotient reaches 2^48 exactly when the top part is not below elapsed
          bw_sat_r <= (TS_W'(num_r[NUM_W-1:BW_W]) >= elap_r);
          br_r     <= TS_W'(num_r[NUM_W-1:BW_W]);
          bq_r     <= num_r[BW_W-1:0];
          step_r   <= '0;
          state_r  <= ST_DIV;
        end
        ST_DIV: begin
          ar_r <= a_ge ? CNT_W'(a_trial - {1'b0, cnt_r}) : a_trial[CNT_W-1:0];
          aq_r <= {aq_r[SUM_W-2:0], a_ge};
          if (step_r < BW_END) begin
            br_r <= b_ge ? TS_W'(b_trial - {1'b0, elap_r}) : b_trial[TS_W-1:0];
            bq_r <= {bq_r[BW_W-2:0], b_ge};
          end
          step_r <= step_r + 1'b1;
          if (step_r == AVG_LAST) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r                <= 1'b1;
            out_data_r.latency_ns      <= lat_r;
            out_data_r.min_latency_ns  <= min_r;
            out_data_r.max_latency_ns  <= max_r;
            out_data_r.avg_latency_ns  <= avg_val;
            out_data_r.seen_count      <= cnt_r;
            out_data_r.bandwidth_bps   <= bw_val;
            state_r                    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/latency_statistics_monitor_core.sv
// ----------------------------------------------------------------------------
// latency_statistics_monitor_core
// Running min / max / average latency and bandwidth monitor.
// ----------------------------------------------------------------------------
// Input channel in_valid / in_stall / in_data carries one send and receive
// timestamp pair per transfer. Each transfer yields exactly one result on
// out_valid / out_stall / out_data holding the latency, running min, max,
// average, sample count and bandwidth in bytes per second.
// cfg_wr_en / cfg_wr_data load the image size in bytes; write it while idle.
// The back handles one item at a time and pops the next only once its
// result is loaded; the average comes from a 64-step restoring divider
// (the 48-step bandwidth divider runs alongside it).
// The front converts timestamps and forms the latency, then parks items in
// a short queue, so up to QUEUE_DEPTH + 1 items are taken while the back
// is busy. A stalled result stays in the output register; the back waits
// with its next result until that one has been taken.
// Synchronous reset clears the statistics (minimum back to 1000 s) and
// restores the image size to 1 MiB; no clearing pass is needed.
// ----------------------------------------------------------------------------
module latency_statistics_monitor_core import lsm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [IMG_W-1:0] cfg_wr_data
);

  logic [IMG_W-1:0] image_bytes_r;
  logic             push, q_full, pop, q_not_empty;
  lsm_item_t        push_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_bytes_r <= IMG_RESET;
    end else if (cfg_wr_en) begin
      image_bytes_r <= cfg_wr_data;
    end
  end

  lsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  lsm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  lsm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .image_bytes (image_bytes_r),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for latency_statistics_monitor_core. Timestamp pairs
// go in through the valid/stall input channel, and an in-bench model tracks
// min, max, average, count and bandwidth for every accepted transfer. Each
// result transfer is checked field by field in order. The image size is
// reprogrammed between phases, and both sides idle at random.
// ----------------------------------------------------------------------------
module testbench import lsm_pkg::*; ();

  localparam longint NS_SEC    = 64'sd1000000000;
  localparam longint LAT_TOP   = 64'sd140737488355327;
  localparam longint LAT_BOT   = -64'sd140737488355328;
  localparam longint SUM_TOP   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_BOT   = 64'sh8000_0000_0000_0000;
  localparam longint MIN_START = 64'sd1000000000000;
  localparam longint TS_TOP    = 64'sd2147483647999999999;
  localparam int unsigned SEC_MAX  = 32'h7FFF_FFFF;
  localparam int unsigned NSEC_MAX = 32'h3FFF_FFFF;
  localparam logic [IMG_W-1:0] IMG_TOP = {IMG_W{1'b1}};
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 800;
  localparam int PHASE_ITEMS = 225;

  // Running latency statistics, plus the results still owed by the block
  class latency_tracker;
    logic [IMG_W-1:0] img_bytes;
    longint           run_min;
    longint           run_max;
    longint           run_sum;
    logic [CNT_W-1:0] seen;
    longint           first_recv;
    bit               have_first;
    out_item_t        expected_stats[$];
    int               errors;

    function new();
      img_bytes  = IMG_RESET;
      run_min    = MIN_START;
      run_max    = 0;
      run_sum    = 0;
      seen       = '0;
      first_recv = 0;
      have_first = 1'b0;
      errors     = 0;
    endfunction

    function out_item_t predict_stats(in_item_t s);
      longint              t_send;
      longint              t_recv;
      longint              lat;
      logic signed [64:0]  total;
      logic signed [64:0]  wide_sum;
      logic signed [64:0]  wide_cnt;
      logic signed [64:0]  mean;
      logic [127:0]        numer;
      logic [127:0]        quot;
      out_item_t           r;
      t_send = longint'(s.send_sec) * NS_SEC + longint'(s.send_nanosec);
      t_recv = longint'(s.recv_sec) * NS_SEC + longint'(s.recv_nanosec);
      lat = t_recv - t_send;
      if (lat > LAT_TOP) lat = LAT_TOP;
      else if (lat < LAT_BOT) lat = LAT_BOT;
      if (!have_first) begin
        have_first = 1'b1;
        first_recv = t_recv;
      end
      if (lat < run_min) run_min = lat;
      if (lat > run_max) run_max = lat;
      total = run_sum + lat;
      if (total > SUM_TOP) run_sum = SUM_TOP;
      else if (total < SUM_BOT) run_sum = SUM_BOT;
      else run_sum = total[63:0];
      if (seen != {CNT_W{1'b1}}) seen++;
      // signed division truncates toward zero
      wide_sum = run_sum;
      wide_cnt = {33'b0, seen};
      mean = wide_sum / wide_cnt;
      if (mean > LAT_TOP) mean = LAT_TOP;
      else if (mean < LAT_BOT) mean = LAT_BOT;
      r.bandwidth_bps = '0;
      if (t_recv > first_recv && img_bytes != '0) begin
        numer = {96'b0, seen} * {101'b0, img_bytes} * 128'd1000000000;
        quot  = numer / {64'b0, t_recv - first_recv};
        r.bandwidth_bps = (quot[127:48] != '0) ? BW_MAX : quot[47:0];
      end
      r.latency_ns     = lat[47:0];
      r.min_latency_ns = run_min[47:0];
      r.max_latency_ns = run_max[47:0];
      r.avg_latency_ns = mean[47:0];
      r.seen_count     = seen;
      return r;
    endfunction

    function void note_sample(in_item_t s);
      expected_stats.push_back(predict_stats(s));
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task compare(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
    endtask

    task check_stats(out_item_t got);
      out_item_t want;
      if (expected_stats.size() == 0) begin
        report("result transfer with no sample outstanding");
        return;
      end
      want = expected_stats.pop_front();
      compare("latency_ns", got.latency_ns, want.latency_ns);
      compare("min_latency_ns", got.min_latency_ns, want.min_latency_ns);
      compare("max_latency_ns", got.max_latency_ns, want.max_latency_ns);
      compare("avg_latency_ns", got.avg_latency_ns, want.avg_latency_ns);
      compare("seen_count", got.seen_count, want.seen_count);
      compare("bandwidth_bps", got.bandwidth_bps, want.bandwidth_bps);
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en = 1'b0;
  logic [IMG_W-1:0] cfg_wr_data = '0;

  latency_tracker tracker = new();
  in_item_t       stim_q[$];
  bit             idle_on = 1'b1;
  int             results_taken = 0;
  int             cycle_count = 0;
  longint         wall_ns = 64'sd1000000001000;

  latency_statistics_monitor_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_item_t sample_of(int unsigned ss, int unsigned sn,
                                         int unsigned rs, int unsigned rn);
    in_item_t s;
    s.send_sec     = ss[30:0];
    s.send_nanosec = sn[29:0];
    s.recv_sec     = rs[30:0];
    s.recv_nanosec = rn[29:0];
    return s;
  endfunction

  function automatic in_item_t split_ts(longint t_s, longint t_r);
    if (t_s < 0) t_s = 0;
    else if (t_s > TS_TOP) t_s = TS_TOP;
    if (t_r < 0) t_r = 0;
    else if (t_r > TS_TOP) t_r = TS_TOP;
    return sample_of(int'(t_s / NS_SEC), int'(t_s % NS_SEC),
                     int'(t_r / NS_SEC), int'(t_r % NS_SEC));
  endfunction

  // Mostly a frame stream on an advancing receive clock; some long or
  // backwards latencies, and some raw noise in every field
  function automatic in_item_t make_random();
    int unsigned pick;
    longint      lat;
    in_item_t    s;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      s.send_sec     = 31'($urandom());
      s.send_nanosec = 30'($urandom());
      s.recv_sec     = 31'($urandom());
      s.recv_nanosec = 30'($urandom());
      return s;
    end
    wall_ns += longint'($urandom_range(0, 20000000));
    if (pick < 85) begin
      lat = longint'($urandom_range(0, 5000000)) - 500000;
    end else begin
      lat = longint'($urandom()) << $urandom_range(0, 30);
      if ($urandom_range(0, 1) == 0) lat = -lat;
    end
    return split_ts(wall_ns - lat, wall_ns);
  endfunction

  task automatic drive_samples();
    in_item_t s;
    int       gap;
    while (stim_q.size() != 0) begin
      s = stim_q.pop_front();
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= s;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      tracker.note_sample(s);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (tracker.expected_stats.size() != 0) @(posedge clk);
  endtask

  task automatic write_image(logic [IMG_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.img_bytes = v;
  endtask

  // Receiver: random stall per result, plus one long hold so the input backs up
  initial begin : result_sink
    int hold;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      hold = idle_on ? $urandom_range(0, 10) : 0;
      if (!held && results_taken == HOLD_AT) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_stats(out_data);
      results_taken++;
    end
  end

  initial begin : stimulus
    logic [IMG_W-1:0] dir_cfg[4];
    logic [IMG_W-1:0] phase_cfg;
    dir_cfg = '{'0, IMG_TOP, 27'd1, 27'd67108864};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first sample: elapsed time is zero whatever the bytes
    stim_q.push_back(sample_of(1000, 0, 1000, 500));
    stim_q.push_back(sample_of(1000, 100, 1000, 500));
    // receive time before the first one, negative latency
    stim_q.push_back(sample_of(999, 999999999, 999, 0));
    // one ns of elapsed time: bandwidth saturates
    stim_q.push_back(sample_of(1000, 0, 1000, 501));
    stim_q.push_back(sample_of(0, 0, 0, 0));
    stim_q.push_back(sample_of(0, 0, SEC_MAX, NSEC_MAX));
    stim_q.push_back(sample_of(SEC_MAX, NSEC_MAX, 0, 0));
    stim_q.push_back(sample_of(SEC_MAX, NSEC_MAX, SEC_MAX, NSEC_MAX));
    // nanoseconds past a whole second are taken as given
    stim_q.push_back(sample_of(5, NSEC_MAX, 6, 0));
    stim_q.push_back(sample_of(1000, 0, 999, 1000000000));
    stim_q.push_back(sample_of(SEC_MAX, 0, SEC_MAX, 999999999));
    // either side of the latency clamp
    stim_q.push_back(sample_of(0, 0, 140737, 488355327));
    stim_q.push_back(sample_of(0, 0, 140737, 488355328));
    stim_q.push_back(sample_of(140737, 488355328, 0, 0));
    stim_q.push_back(sample_of(140737, 488355329, 0, 0));
    drive_samples();
    drain();

    // image size extremes, zero included
    for (int k = 0; k < 4; k++) begin
      write_image(dir_cfg[k]);
      stim_q.push_back(sample_of(1000, 200, 1000, 600 + k));
      stim_q.push_back(sample_of(1999999999, 0, 2000000000, 0));
      drive_samples();
      drain();
    end

    for (int p = 0; p < 6; p++) begin
      unique case (p)
        1:       phase_cfg = IMG_TOP;
        2:       phase_cfg = 27'd1;
        3:       phase_cfg = 27'd67108864;
        5:       phase_cfg = IMG_RESET;
        default: phase_cfg = IMG_W'($urandom_range(1, 67108864));
      endcase
      write_image(phase_cfg);
      idle_on = (p != 1 && p != 4);
      for (int i = 0; i < PHASE_ITEMS; i++) stim_q.push_back(make_random());
      drive_samples();
      drain();
    end

    // let any stray result show up before the verdict
    repeat (100) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: latency_statistics_monitor_core.f
design/lsm_pkg.sv
design/lsm_front.sv
design/lsm_fifo.sv
design/lsm_back.sv
design/latency_statistics_monitor_core.sv
bench/testbench.sv
